@@ rtl/smdi_pkg.sv @@
// Package for the small matrix direct inverse core.
// Pipeline depths, field widths and the divider stage types; no dependencies.
package smdi_pkg;

    localparam int FRONT   = 6;               // cofactor, determinant and operand stages
    localparam int DIV_STG = 32;              // overflow check plus one quotient bit a stage
    localparam int PIPE    = FRONT + DIV_STG; // stages before the output word register

    localparam int NUM_W = 57;                // 2*|adj|*2^16 + |det|
    localparam int DEN_W = 49;                // 2*|det|
    localparam int QUO_W = 31;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_side;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] lo;
        logic [QUO_W-1:0] quo;
        logic [DEN_W-1:0] den;
        logic             ovf;
        t_side            side;
    } t_div_st;

    typedef struct packed {
        logic             sing;
        logic [8:0][31:0] b;
    } t_res;

endpackage

@@ rtl/smdi_div_lane.sv @@
// Pipelined restoring divider lane: rounded quotient magnitude with overflow flag.
// Depends on smdi_pkg.
module smdi_div_lane (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [smdi_pkg::NUM_W-1:0]   i_num,
    input  logic [smdi_pkg::DEN_W-1:0]   i_den,
    input  smdi_pkg::t_side              i_side,
    output logic [smdi_pkg::QUO_W-1:0]   o_quo,
    output logic                         o_ovf,
    output smdi_pkg::t_side              o_side
);

    localparam int HI_W = smdi_pkg::NUM_W - smdi_pkg::QUO_W;

    smdi_pkg::t_div_st r_st [smdi_pkg::DIV_STG];

    // first stage: quotient >= 2^31 check, remainder seeded with the high bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].rem  <= {{(smdi_pkg::DEN_W-HI_W){1'b0}}, i_num[smdi_pkg::NUM_W-1 -: HI_W]};
            r_st[0].lo   <= i_num[smdi_pkg::QUO_W-1:0];
            r_st[0].quo  <= '0;
            r_st[0].den  <= i_den;
            r_st[0].ovf  <= {{(smdi_pkg::DEN_W-HI_W){1'b0}},
                             i_num[smdi_pkg::NUM_W-1 -: HI_W]} >= i_den;
            r_st[0].side <= i_side;
        end
    end

    for (genvar j = 1; j < smdi_pkg::DIV_STG; j++) begin : g_step
        logic [smdi_pkg::DEN_W:0] w_cur;
        logic [smdi_pkg::DEN_W:0] w_trial;
        logic                     w_borrow;

        assign w_cur    = {r_st[j-1].rem, r_st[j-1].lo[smdi_pkg::QUO_W-1]};
        assign w_trial  = w_cur - {1'b0, r_st[j-1].den};
        assign w_borrow = w_trial[smdi_pkg::DEN_W];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j].rem  <= w_borrow ? w_cur[smdi_pkg::DEN_W-1:0]
                                         : w_trial[smdi_pkg::DEN_W-1:0];
                r_st[j].lo   <= {r_st[j-1].lo[smdi_pkg::QUO_W-2:0], 1'b0};
                r_st[j].quo  <= {r_st[j-1].quo[smdi_pkg::QUO_W-2:0], ~w_borrow};
                r_st[j].den  <= r_st[j-1].den;
                r_st[j].ovf  <= r_st[j-1].ovf;
                r_st[j].side <= r_st[j-1].side;
            end
        end
    end

    assign o_quo  = r_st[smdi_pkg::DIV_STG-1].quo;
    assign o_ovf  = r_st[smdi_pkg::DIV_STG-1].ovf;
    assign o_side = r_st[smdi_pkg::DIV_STG-1].side;

endmodule

@@ rtl/small_matrix_direct_inverse_core.sv @@
// Adjugate inverse of a 1x1, 2x2 or 3x3 Q8.8 matrix, Q16.16 result with saturation.
// Depends on smdi_pkg and smdi_div_lane.
//
// One matrix word is accepted every cycle while the input is not stalled, and its
// result passes through 6 stages of cofactor products, determinant and operand setup,
// 32 stages of the nine bit-per-stage divider lanes, then the output word register;
// the first stage loads at the accepting edge. A skid register behind the
// output keeps the pipeline moving while one result waits, so input stall only rises
// when the next result reaches the end of the pipeline while the output word is
// stalled. The threshold register is written through a port that is always ready.
module small_matrix_direct_inverse_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_size,
    input  logic signed [15:0] i_a00,
    input  logic signed [15:0] i_a01,
    input  logic signed [15:0] i_a02,
    input  logic signed [15:0] i_a10,
    input  logic signed [15:0] i_a11,
    input  logic signed [15:0] i_a12,
    input  logic signed [15:0] i_a20,
    input  logic signed [15:0] i_a21,
    input  logic signed [15:0] i_a22,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_singular,
    output logic signed [31:0] o_b00,
    output logic signed [31:0] o_b01,
    output logic signed [31:0] o_b02,
    output logic signed [31:0] o_b10,
    output logic signed [31:0] o_b11,
    output logic signed [31:0] o_b12,
    output logic signed [31:0] o_b20,
    output logic signed [31:0] o_b21,
    output logic signed [31:0] o_b22
);

    localparam int P = smdi_pkg::PIPE;

    logic [31:0]  r_min_det;
    logic [P-1:0] r_v;
    logic         w_en;

    // ---------------- config
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_det <= 32'd1;
        end else if (i_cfg_valid) begin
            r_min_det <= i_cfg_data;
        end
    end

    // ---------------- valid pipeline, global advance unless skid is full
    logic r_out_v, r_skid_v;
    assign w_en       = ~r_skid_v;
    assign o_in_stall = ~w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[P-2:0], i_in_valid};
        end
    end

    // ---------------- stage 1: cofactor products
    logic signed [15:0] w_a [9];
    assign w_a = '{i_a00, i_a01, i_a02, i_a10, i_a11, i_a12, i_a20, i_a21, i_a22};

    logic signed [31:0] w_pa [9];
    logic signed [31:0] w_pb [9];
    always_comb begin
        w_pa[0] = w_a[4] * w_a[8];  w_pb[0] = w_a[5] * w_a[7];
        w_pa[1] = w_a[2] * w_a[7];  w_pb[1] = w_a[1] * w_a[8];
        w_pa[2] = w_a[1] * w_a[5];  w_pb[2] = w_a[2] * w_a[4];
        w_pa[3] = w_a[5] * w_a[6];  w_pb[3] = w_a[3] * w_a[8];
        w_pa[4] = w_a[0] * w_a[8];  w_pb[4] = w_a[2] * w_a[6];
        w_pa[5] = w_a[2] * w_a[3];  w_pb[5] = w_a[0] * w_a[5];
        w_pa[6] = w_a[3] * w_a[7];  w_pb[6] = w_a[4] * w_a[6];
        w_pa[7] = w_a[1] * w_a[6];  w_pb[7] = w_a[0] * w_a[7];
        w_pa[8] = w_a[0] * w_a[4];  w_pb[8] = w_a[1] * w_a[3];
    end

    logic [1:0]         r1_n;
    logic signed [15:0] r1_a [9];
    logic signed [31:0] r1_pa [9];
    logic signed [31:0] r1_pb [9];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_n  <= i_size;
            r1_a  <= w_a;
            r1_pa <= w_pa;
            r1_pb <= w_pb;
        end
    end

    // ---------------- stage 2: cofactors
    logic [1:0]         r2_n;
    logic signed [15:0] r2_a [9];
    logic signed [32:0] r2_cof [9];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_n <= r1_n;
            r2_a <= r1_a;
            for (int k = 0; k < 9; k++) begin
                r2_cof[k] <= {r1_pa[k][31], r1_pa[k]} - {r1_pb[k][31], r1_pb[k]};
            end
        end
    end

    // ---------------- stage 3: determinant terms, adjugate in Q17.24
    logic signed [48:0] w_d [3];
    logic signed [40:0] w_adj [9];
    logic signed [48:0] w_dalt;
    logic [8:0]         w_mask;
    always_comb begin
        w_d[0] = r2_a[0] * r2_cof[0];
        w_d[1] = r2_a[1] * r2_cof[3];
        w_d[2] = r2_a[2] * r2_cof[6];
        for (int k = 0; k < 9; k++) begin
            w_adj[k]  = '0;
            w_mask[k] = ((k / 3) < int'(r2_n)) && ((k % 3) < int'(r2_n));
        end
        w_dalt = '0;
        case (r2_n)
            2'd3: begin
                for (int k = 0; k < 9; k++) begin
                    w_adj[k] = {r2_cof[k], 8'b0};
                end
            end
            2'd2: begin
                w_adj[0] = {{9{r2_a[4][15]}}, r2_a[4], 16'b0};
                w_adj[1] = -{{9{r2_a[1][15]}}, r2_a[1], 16'b0};
                w_adj[3] = -{{9{r2_a[3][15]}}, r2_a[3], 16'b0};
                w_adj[4] = {{9{r2_a[0][15]}}, r2_a[0], 16'b0};
                w_dalt   = {{8{r2_cof[8][32]}}, r2_cof[8], 8'b0};
            end
            2'd1: begin
                w_adj[0] = 41'sd16777216;
                w_dalt   = {{17{r2_a[0][15]}}, r2_a[0], 16'b0};
            end
            default: begin
            end
        endcase
    end

    logic [1:0]         r3_n;
    logic signed [48:0] r3_d [3];
    logic signed [48:0] r3_dalt;
    logic signed [40:0] r3_adj [9];
    logic [8:0]         r3_mask;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_n    <= r2_n;
            r3_d    <= w_d;
            r3_dalt <= w_dalt;
            r3_adj  <= w_adj;
            r3_mask <= w_mask;
        end
    end

    // ---------------- stage 4: determinant sum, adjugate magnitudes
    logic [1:0]         r4_n;
    logic signed [49:0] r4_det;
    logic [39:0]        r4_un [9];
    logic [8:0]         r4_sgn;
    logic [8:0]         r4_mask;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_n    <= r3_n;
            r4_mask <= r3_mask;
            r4_det  <= (r3_n == 2'd3)
                     ? {r3_d[0][48], r3_d[0]} + {r3_d[1][48], r3_d[1]}
                       + {r3_d[2][48], r3_d[2]}
                     : {r3_dalt[48], r3_dalt};
            for (int k = 0; k < 9; k++) begin
                r4_sgn[k] <= r3_adj[k][40];
                r4_un[k]  <= r3_adj[k][40] ? 40'(-r3_adj[k]) : r3_adj[k][39:0];
            end
        end
    end

    // ---------------- stage 5: determinant magnitude
    logic [1:0]  r5_n;
    logic [47:0] r5_ud;
    logic        r5_dsgn;
    logic [39:0] r5_un [9];
    logic [8:0]  r5_sgn;
    logic [8:0]  r5_mask;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_n    <= r4_n;
            r5_un   <= r4_un;
            r5_sgn  <= r4_sgn;
            r5_mask <= r4_mask;
            r5_dsgn <= r4_det[49];
            r5_ud   <= r4_det[49] ? 48'(-r4_det) : r4_det[47:0];
        end
    end

    // ---------------- stage 6: singular test, divider operands
    logic                        w_sing;
    assign w_sing = (r5_n == 2'd0) || (r5_ud == '0) || (r5_ud < {16'b0, r_min_det});

    logic                             r6_sing;
    logic [smdi_pkg::NUM_W-1:0]       r6_num [9];
    logic [smdi_pkg::DEN_W-1:0]       r6_den;
    smdi_pkg::t_side                  r6_side [9];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_sing <= w_sing;
            r6_den  <= {r5_ud, 1'b0};
            for (int k = 0; k < 9; k++) begin
                r6_num[k]       <= {r5_un[k], 17'b0} + {9'b0, r5_ud};
                r6_side[k].neg  <= r5_sgn[k] ^ r5_dsgn;
                r6_side[k].zero <= w_sing | ~r5_mask[k];
            end
        end
    end

    // ---------------- divider lanes
    logic [smdi_pkg::QUO_W-1:0] w_quo [9];
    logic [8:0]                 w_ovf;
    smdi_pkg::t_side            w_side [9];

    for (genvar k = 0; k < 9; k++) begin : g_lane
        smdi_div_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r6_num[k]),
            .i_den  (r6_den),
            .i_side (r6_side[k]),
            .o_quo  (w_quo[k]),
            .o_ovf  (w_ovf[k]),
            .o_side (w_side[k])
        );
    end

    logic r_sing_d [smdi_pkg::DIV_STG];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sing_d[0] <= r6_sing;
            for (int j = 1; j < smdi_pkg::DIV_STG; j++) begin
                r_sing_d[j] <= r_sing_d[j-1];
            end
        end
    end

    // ---------------- sign and saturation
    smdi_pkg::t_res w_res;
    always_comb begin
        w_res.sing = r_sing_d[smdi_pkg::DIV_STG-1];
        for (int k = 0; k < 9; k++) begin
            if (w_side[k].zero) begin
                w_res.b[k] = '0;
            end else if (w_ovf[k]) begin
                w_res.b[k] = w_side[k].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else if (w_side[k].neg) begin
                w_res.b[k] = -{1'b0, w_quo[k]};
            end else begin
                w_res.b[k] = {1'b0, w_quo[k]};
            end
        end
    end

    // ---------------- output word register with skid
    smdi_pkg::t_res r_out, r_skid;
    logic           w_pv, w_take;
    assign w_pv   = r_v[P-1] & w_en;
    assign w_take = r_out_v & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || w_take) begin
            r_out_v  <= r_skid_v | w_pv;
            r_skid_v <= 1'b0;
        end else if (w_pv) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || w_take) begin
            r_out <= r_skid_v ? r_skid : w_res;
        end else if (w_pv) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_singular  = r_out.sing;
    assign o_b00       = r_out.b[0];
    assign o_b01       = r_out.b[1];
    assign o_b02       = r_out.b[2];
    assign o_b10       = r_out.b[3];
    assign o_b11       = r_out.b[4];
    assign o_b12       = r_out.b[5];
    assign o_b20       = r_out.b[6];
    assign o_b21       = r_out.b[7];
    assign o_b22       = r_out.b[8];

    // ---------------- assertions
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word held without output word");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_v && $past(i_out_stall)))
        else $error("input stalled while output side free");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_singular) |-> (o_b00 == 0 && o_b01 == 0 && o_b02 == 0 &&
            o_b10 == 0 && o_b11 == 0 && o_b12 == 0 && o_b20 == 0 && o_b21 == 0 &&
            o_b22 == 0))
        else $error("singular word with nonzero entries");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_v == '0 && !r_out_v && !r_skid_v))
        else $error("pipeline not empty after reset");

endmodule

@@ verif/small_matrix_direct_inverse_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for small_matrix_direct_inverse_core: directed and random
// matrices under random valid/stall gaps, checked against typed expected words or
// an in-bench adjugate predictor. Depends on smdi_pkg and the core RTL.
module small_matrix_direct_inverse_core_tb;

    localparam int HOLD_CYC  = 400;
    localparam int WDOG_LIM  = 4000;
    localparam int DRAIN_CYC = smdi_pkg::PIPE + 8;
    localparam int N_RAND    = 450;

    typedef struct {
        logic [1:0]       size;
        logic [8:0][15:0] a;
        bit               typed;
        smdi_pkg::t_res   want;
    } t_mat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [31:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_size = '0;
    logic signed [15:0] i_a00 = '0, i_a01 = '0, i_a02 = '0;
    logic signed [15:0] i_a10 = '0, i_a11 = '0, i_a12 = '0;
    logic signed [15:0] i_a20 = '0, i_a21 = '0, i_a22 = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_singular;
    logic signed [31:0] o_b00, o_b01, o_b02, o_b10, o_b11, o_b12, o_b20, o_b21, o_b22;

    smdi_pkg::t_res inverse_q[$];
    logic [31:0]    det_thresh = 32'd1;
    int             mismatches = 0;
    int             idle_cnt = 0;
    bit             hold_req = 1'b0;
    bit             quiet = 1'b0;
    int             stall_left = 0;

    small_matrix_direct_inverse_core i_dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic logic [31:0] round_div_sat(longint num, longint den);
        longint un, ud, q;
        bit     neg;
        un  = num < 0 ? -num : num;
        ud  = den < 0 ? -den : den;
        q   = (2 * un + ud) / (2 * ud);
        neg = (num < 0) != (den < 0);
        if (neg) return q >= 64'sd2147483648 ? 32'h8000_0000 : 32'(-q);
        return q > 64'sd2147483647 ? 32'h7fff_ffff : 32'(q);
    endfunction

    function automatic smdi_pkg::t_res predict_inverse(logic [1:0] n, logic [8:0][15:0] a,
                                                       logic [31:0] thr);
        longint         m[3][3];
        longint         adj[3][3];
        longint         det, mag;
        smdi_pkg::t_res res;
        det = 0;
        for (int k = 0; k < 9; k++) begin
            m[k/3][k%3]   = longint'($signed(a[k]));
            adj[k/3][k%3] = 0;
        end
        if (n == 1) begin
            det = m[0][0] * 65536;
            adj[0][0] = 16777216;
        end else if (n == 2) begin
            det = (m[0][0] * m[1][1] - m[0][1] * m[1][0]) * 256;
            adj[0][0] = m[1][1] * 65536;
            adj[0][1] = -m[0][1] * 65536;
            adj[1][0] = -m[1][0] * 65536;
            adj[1][1] = m[0][0] * 65536;
        end else if (n == 3) begin
            adj[0][0] = m[1][1] * m[2][2] - m[1][2] * m[2][1];
            adj[1][0] = m[1][2] * m[2][0] - m[1][0] * m[2][2];
            adj[2][0] = m[1][0] * m[2][1] - m[1][1] * m[2][0];
            adj[0][1] = m[0][2] * m[2][1] - m[0][1] * m[2][2];
            adj[1][1] = m[0][0] * m[2][2] - m[0][2] * m[2][0];
            adj[2][1] = m[0][1] * m[2][0] - m[0][0] * m[2][1];
            adj[0][2] = m[0][1] * m[1][2] - m[0][2] * m[1][1];
            adj[1][2] = m[0][2] * m[1][0] - m[0][0] * m[1][2];
            adj[2][2] = m[0][0] * m[1][1] - m[0][1] * m[1][0];
            det = m[0][0] * adj[0][0] + m[0][1] * adj[1][0] + m[0][2] * adj[2][0];
            for (int k = 0; k < 9; k++) adj[k/3][k%3] = adj[k/3][k%3] * 256;
        end
        mag = det < 0 ? -det : det;
        res = '0;
        if (n == 0 || det == 0 || mag < longint'({32'd0, thr})) begin
            res.sing = 1'b1;
            return res;
        end
        for (int k = 0; k < 9; k++)
            if (k / 3 < n && k % 3 < n)
                res.b[k] = round_div_sat(adj[k/3][k%3] * 65536, det);
        return res;
    endfunction

    function automatic t_mat mk(int n, int e0, int e1, int e2, int e3, int e4,
                                int e5, int e6, int e7, int e8);
        t_mat it;
        it.size  = 2'(n);
        it.a     = {16'(e8), 16'(e7), 16'(e6), 16'(e5), 16'(e4),
                    16'(e3), 16'(e2), 16'(e1), 16'(e0)};
        it.typed = 1'b0;
        it.want  = '0;
        return it;
    endfunction

    function automatic t_mat rand_matrix();
        t_mat it;
        int   pick;
        it   = mk(2'($urandom_range(1, 3)), 0, 0, 0, 0, 0, 0, 0, 0, 0);
        if ($urandom_range(0, 99) < 4) it.size = 2'd0;
        pick = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++)
            case (pick)
                0, 1, 2: it.a[k] = 16'($urandom);
                3, 4:    it.a[k] = 16'($urandom_range(0, 1200) - 600);
                5:       it.a[k] = 16'($urandom_range(0, 8) - 4);
                default: it.a[k] = 16'($urandom_range(0, 160) - 80)
                                   + ((k % 4 == 0) ? 16'd256 : 16'd0);
            endcase
        if (pick == 9) begin
            for (int c = 0; c < 3; c++) it.a[3 + c] = it.a[c];
            if ($urandom_range(0, 1)) it.a[4] = it.a[4] + 16'd1;
        end
        return it;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_matrix(t_mat it);
        int g;
        i_size     <= it.size;
        i_a00      <= it.a[0];
        i_a01      <= it.a[1];
        i_a02      <= it.a[2];
        i_a10      <= it.a[3];
        i_a11      <= it.a[4];
        i_a12      <= it.a[5];
        i_a20      <= it.a[6];
        i_a21      <= it.a[7];
        i_a22      <= it.a[8];
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        inverse_q.push_back(it.typed ? it.want : predict_inverse(it.size, it.a, det_thresh));
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic write_thresh(logic [31:0] v);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (inverse_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        det_thresh  = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int cnt);
        for (int i = 0; i < cnt; i++) begin
            if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
            send_matrix(rand_matrix());
        end
        quiet = 1'b0;
    endtask

    // output side: random stall, one long hold on request
    initial begin
        int r;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYC) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (quiet || r < 65) begin
                    i_out_stall <= 1'b0;
                end else begin
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                    i_out_stall <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        smdi_pkg::t_res got, exp_w;
        got.sing = o_singular;
        got.b    = {o_b22, o_b21, o_b20, o_b12, o_b11, o_b10, o_b02, o_b01, o_b00};
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (inverse_q.size() == 0) begin
                $error("unexpected output word");
                mismatches++;
            end else begin
                exp_w = inverse_q.pop_front();
                if (got.sing !== exp_w.sing) begin
                    $error("singular: expected %0d, got %0d", exp_w.sing, got.sing);
                    mismatches++;
                end
                for (int k = 0; k < 9; k++)
                    if (got.b[k] !== exp_w.b[k]) begin
                        $error("b%0d%0d: expected %0d, got %0d", k / 3, k % 3,
                               $signed(exp_w.b[k]), $signed(got.b[k]));
                        mismatches++;
                    end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_LIM) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_mat dir[$];
        t_mat it;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset threshold of one: typed rows
        it = mk(1, 256, 0, 0, 0, 0, 0, 0, 0, 0);
        it.typed = 1'b1; it.want.b[0] = 32'h0001_0000; dir.push_back(it);
        it = mk(2, 256, 0, 77, 0, 256, -9, 5, 5, 5);
        it.typed = 1'b1; it.want.b[0] = 32'h0001_0000; it.want.b[4] = 32'h0001_0000;
        dir.push_back(it);
        it = mk(3, 256, 0, 0, 0, 256, 0, 0, 0, 256);
        it.typed = 1'b1; it.want.b[0] = 32'h0001_0000; it.want.b[4] = 32'h0001_0000;
        it.want.b[8] = 32'h0001_0000; dir.push_back(it);
        it = mk(1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        it.typed = 1'b1; it.want.b[0] = 32'h0100_0000; dir.push_back(it);
        it = mk(0, 256, 1, 2, 3, 256, 4, 5, 6, 256);
        it.typed = 1'b1; it.want.sing = 1'b1; dir.push_back(it);
        it = mk(3, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        it.typed = 1'b1; it.want.sing = 1'b1; dir.push_back(it);
        it = mk(2, 256, 512, 0, 512, 1024, 0, 0, 0, 0);
        it.typed = 1'b1; it.want.sing = 1'b1; dir.push_back(it);
        // predictor rows: extremes, saturation, negatives
        dir.push_back(mk(1, -32768, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        dir.push_back(mk(1, 32767, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                         -32768));
        dir.push_back(mk(1, -1, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(2, 32767, -32768, 0, -32768, 32767, 0, 0, 0, 0));
        dir.push_back(mk(2, -32768, 32767, 0, 32767, -32768, 0, 0, 0, 0));
        dir.push_back(mk(2, 1, 1, 0, 0, 1, 0, 0, 0, 0));
        dir.push_back(mk(3, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767,
                         -32768));
        dir.push_back(mk(3, -32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767,
                         32767));
        dir.push_back(mk(3, 1, 32767, 0, 0, 1, 32767, 32767, 0, 1));
        dir.push_back(mk(3, 1, 0, 0, 0, 1, 0, 0, 0, 1));
        dir.push_back(mk(3, 2, 3, 5, 7, 11, 13, 17, 19, 23));
        dir.push_back(mk(3, -300, 120, 45, 600, -256, 77, -12, 900, 511));
        foreach (dir[i]) send_matrix(dir[i]);

        write_thresh(32'd0);
        dir.push_back(mk(2, 1, 0, 0, 0, 1, 0, 0, 0, 0));
        dir.push_back(mk(3, 3, 3, 3, 3, 3, 3, 3, 3, 3));
        foreach (dir[i]) if (i >= dir.size() - 2) send_matrix(dir[i]);
        hold_req = 1'b1;
        run_random(N_RAND);

        write_thresh(32'hffff_ffff);
        run_random(N_RAND);

        write_thresh(32'h0100_0000);
        run_random(N_RAND);

        write_thresh(32'd1);
        run_random(N_RAND);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (inverse_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ small_matrix_direct_inverse_core.f @@
rtl/smdi_pkg.sv
rtl/smdi_div_lane.sv
rtl/small_matrix_direct_inverse_core.sv
verif/small_matrix_direct_inverse_core_tb.sv
